// ===== rtl/core/pwmps_pkg.sv =====
`timescale 1ns / 1ps

package pwmps_pkg;

	// Datapath widths
	localparam int DIV_W = 30;
	localparam int CLK_W = 27;

	// Prescaler search limits
	localparam int MAX_PRESCALE = 256;
	localparam int MAX_LOG2     = $clog2(MAX_PRESCALE + 1) - 1;
	localparam int COUNT_LIMIT  = 65535;

	// Fixed constants
	localparam logic [DIV_W-1:0] NS_PER_S        = 30'd1000000000;
	localparam logic [CLK_W-1:0] CLOCK_HZ_RESET  = 27'd24000000;
	localparam logic [9:0]       NS_PER_US       = 10'd1000;
	localparam logic [9:0]       DUTY_MAX        = 10'd1000;
	localparam logic [19:0]      HIGH_MAX_US     = 20'd5000;
	localparam logic [19:0]      HIGH_MAX_CH4_US = 20'd2500;
	localparam logic [8:0]       PIN_FIRST       = 9'd267;
	localparam logic [8:0]       PIN_LAST        = 9'd270;
	localparam logic [8:0]       PIN_BASE        = 9'd266;
	localparam logic [2:0]       CHAN_NONE       = 3'd0;
	localparam logic [2:0]       CHAN_FIXED      = 3'd4;

	// Reciprocal of 1000 scaled by 2^40, exact for dividends below 2^30
	localparam int               KILO_SHIFT      = 40;
	localparam logic [30:0]      KILO_RECIP      = 31'd1099511628;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_BAD_PIN   = 3'd1,
		STAT_BAD_FREQ  = 3'd2,
		STAT_BAD_DUTY  = 3'd3,
		STAT_HIGH_LONG = 3'd4,
		STAT_NO_FIT    = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_TICK,
		S_PER,
		S_KILO,
		S_DUTY,
		S_QP,
		S_QA,
		S_SEARCH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/core/pwmps_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module pwmps_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pwmps_pkg::div_req_t  req,
	output pwmps_pkg::div_rsp_t  rsp
);

	localparam int DW    = pwmps_pkg::DIV_W;
	localparam int CNT_W = $clog2(DW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [DW-1:0]    dsr_q;

	logic [DW:0]      trial;
	logic [DW:0]      diff;
	logic             fits;

	// Trial subtract of the shifted remainder
	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== rtl/core/pwm_prescale_period_solver_top.sv =====
`timescale 1ns / 1ps

// Channel   Signals                              Carries
// s         s_tvalid s_tready s_tdata s_tuser    one request
// m         m_tvalid m_tready m_tdata m_tuser    one result per request
// cfg       cfg_valid cfg_ready cfg_data         clock_hz register write
//
// A request that fails a check goes from the check straight to the result;
// otherwise it runs its divisions one after another on the shared restoring
// divider: time mode runs three, frequency mode four plus two multiply steps;
// the prescaler search, skipped on the fixed channel, adds one step per prescaler tried.
// s_tready is high only when idle.
// A finished result waits in the output register while m_tready is low.
// Reset is asynchronous, active low; clock_hz returns to 24000000.
module pwm_prescale_period_solver_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// pin_number[8:0], frequency_hz[28:9], duty_permille[38:29],
	// high_time_us[58:39], period_time_us[78:59], zero pad[79]
	input  logic [79:0] s_tdata,
	// operation[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// channel[2:0], prescale_log2[6:3], period_count[22:7],
	// active_count[38:23], zero pad[39]
	output logic [39:0] m_tdata,
	// status[2:0]
	output logic [2:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [26:0] cfg_data
);

	localparam int DW = pwmps_pkg::DIV_W;

	pwmps_pkg::state_t   state_q, state_d;
	pwmps_pkg::status_t  status_q, check_status;
	pwmps_pkg::div_req_t div_req;
	pwmps_pkg::div_rsp_t div_rsp;

	logic [26:0] clock_hz_q;
	logic [26:0] clk_eff;

	logic        op_q;
	logic [8:0]  pin_q;
	logic [19:0] freq_q;
	logic [9:0]  duty_q;
	logic [19:0] high_q;
	logic [19:0] per_us_q;

	logic [2:0]    ch_q;
	logic [DW-1:0] tick_q;
	logic [DW-1:0] per_ns_q;
	logic [DW-1:0] act_q;
	logic [DW-1:0] qp_q;
	logic [DW-1:0] qa_q;
	logic [3:0]    lg_q;
	logic          launched_q;

	logic          m_tvalid_q;
	logic [2:0]    out_status_q;
	logic [2:0]    out_ch_q;
	logic [3:0]    out_lg_q;
	logic [15:0]   out_pc_q;
	logic [15:0]   out_ac_q;

	logic          pin_ok;
	logic [2:0]    ch_calc;
	logic [DW-1:0] freq_k;
	logic [60:0]   kilo_prod;
	logic          fit;
	logic          div_state;
	logic          s_xfer;
	logic          out_load;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= pwmps_pkg::CLOCK_HZ_RESET;
		end else if (cfg_valid) begin
			clock_hz_q <= cfg_data;
		end
	end

	assign clk_eff = (clock_hz_q == '0) ? 27'd1 : clock_hz_q;

	// Request checks, in priority order
	assign pin_ok  = (pin_q >= pwmps_pkg::PIN_FIRST) && (pin_q <= pwmps_pkg::PIN_LAST);
	assign ch_calc = 3'(pin_q - pwmps_pkg::PIN_BASE);
	assign freq_k  = DW'(freq_q) * DW'(pwmps_pkg::NS_PER_US);

	always_comb begin
		check_status = pwmps_pkg::STAT_OK;
		if (!pin_ok) begin
			check_status = pwmps_pkg::STAT_BAD_PIN;
		end else if (!op_q) begin
			if (freq_k > DW'(clk_eff)) begin
				check_status = pwmps_pkg::STAT_BAD_FREQ;
			end else if (duty_q > pwmps_pkg::DUTY_MAX) begin
				check_status = pwmps_pkg::STAT_BAD_DUTY;
			end else if (freq_q == '0) begin
				check_status = pwmps_pkg::STAT_BAD_FREQ;
			end
		end else begin
			if (high_q > pwmps_pkg::HIGH_MAX_US) begin
				check_status = pwmps_pkg::STAT_HIGH_LONG;
			end else if (ch_calc == pwmps_pkg::CHAN_FIXED &&
			             high_q > pwmps_pkg::HIGH_MAX_CH4_US) begin
				check_status = pwmps_pkg::STAT_HIGH_LONG;
			end
		end
	end

	// Period in microseconds by reciprocal multiply
	assign kilo_prod = 61'(per_ns_q) * 61'(pwmps_pkg::KILO_RECIP);

	// Both counts fit at the current prescaler
	assign fit = (qp_q <= DW'(pwmps_pkg::COUNT_LIMIT)) && (qa_q <= DW'(pwmps_pkg::COUNT_LIMIT));

	assign s_xfer   = s_tvalid && s_tready;
	assign out_load = (state_q == pwmps_pkg::S_DONE) && (!m_tvalid_q || m_tready);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwmps_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and divider operands
	always_comb begin
		state_d          = state_q;
		s_tready         = 1'b0;
		div_state        = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		case (state_q)
			pwmps_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = pwmps_pkg::S_CHECK;
				end
			end
			pwmps_pkg::S_CHECK: begin
				state_d = (check_status == pwmps_pkg::STAT_OK) ?
				          pwmps_pkg::S_TICK : pwmps_pkg::S_DONE;
			end
			pwmps_pkg::S_TICK: begin
				div_state        = 1'b1;
				div_req.dividend = pwmps_pkg::NS_PER_S;
				div_req.divisor  = DW'(clk_eff);
				if (div_rsp.done) begin
					state_d = op_q ? pwmps_pkg::S_QP : pwmps_pkg::S_PER;
				end
			end
			pwmps_pkg::S_PER: begin
				div_state        = 1'b1;
				div_req.dividend = pwmps_pkg::NS_PER_S;
				div_req.divisor  = DW'(freq_q);
				if (div_rsp.done) begin
					state_d = pwmps_pkg::S_KILO;
				end
			end
			pwmps_pkg::S_KILO: begin
				state_d = pwmps_pkg::S_DUTY;
			end
			pwmps_pkg::S_DUTY: begin
				state_d = pwmps_pkg::S_QP;
			end
			pwmps_pkg::S_QP: begin
				div_state        = 1'b1;
				div_req.dividend = per_ns_q;
				div_req.divisor  = tick_q;
				if (div_rsp.done) begin
					state_d = pwmps_pkg::S_QA;
				end
			end
			pwmps_pkg::S_QA: begin
				div_state        = 1'b1;
				div_req.dividend = act_q;
				div_req.divisor  = tick_q;
				if (div_rsp.done) begin
					state_d = (ch_q == pwmps_pkg::CHAN_FIXED) ?
					          pwmps_pkg::S_DONE : pwmps_pkg::S_SEARCH;
				end
			end
			pwmps_pkg::S_SEARCH: begin
				if (fit || lg_q == 4'(pwmps_pkg::MAX_LOG2)) begin
					state_d = pwmps_pkg::S_DONE;
				end
			end
			pwmps_pkg::S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = pwmps_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pwmps_pkg::S_IDLE;
			end
		endcase
		div_req.start = div_state && !launched_q;
	end

	// Launch flag: one start per division state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launched_q <= 1'b0;
		end else if (div_rsp.done) begin
			launched_q <= 1'b0;
		end else if (div_req.start) begin
			launched_q <= 1'b1;
		end
	end

	// Request capture and working registers
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			op_q     <= s_tuser[0];
			pin_q    <= s_tdata[8:0];
			freq_q   <= s_tdata[28:9];
			duty_q   <= s_tdata[38:29];
			high_q   <= s_tdata[58:39];
			per_us_q <= s_tdata[78:59];
		end
		case (state_q)
			pwmps_pkg::S_CHECK: begin
				status_q <= check_status;
				ch_q     <= pin_ok ? ch_calc : pwmps_pkg::CHAN_NONE;
				lg_q     <= '0;
				per_ns_q <= DW'(per_us_q) * DW'(pwmps_pkg::NS_PER_US);
				act_q    <= DW'(high_q) * DW'(pwmps_pkg::NS_PER_US);
			end
			pwmps_pkg::S_TICK: begin
				if (div_rsp.done) begin
					tick_q <= div_rsp.quotient;
				end
			end
			pwmps_pkg::S_PER: begin
				if (div_rsp.done) begin
					per_ns_q <= div_rsp.quotient;
				end
			end
			pwmps_pkg::S_KILO: begin
				act_q <= DW'(kilo_prod[pwmps_pkg::KILO_SHIFT +: 20]);
			end
			pwmps_pkg::S_DUTY: begin
				act_q <= DW'(act_q[19:0]) * DW'(duty_q);
			end
			pwmps_pkg::S_QP: begin
				if (div_rsp.done) begin
					qp_q <= div_rsp.quotient;
				end
			end
			pwmps_pkg::S_QA: begin
				if (div_rsp.done) begin
					qa_q <= div_rsp.quotient;
				end
			end
			pwmps_pkg::S_SEARCH: begin
				// Advance one prescaler step while the counts do not fit: halve both counts, or flag no fit at the top step
				if (!fit) begin
					if (lg_q == 4'(pwmps_pkg::MAX_LOG2)) begin
						status_q <= pwmps_pkg::STAT_NO_FIT;
					end else begin
						qp_q <= qp_q >> 1;
						qa_q <= qa_q >> 1;
						lg_q <= lg_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_ch_q     <= ch_q;
			if (status_q == pwmps_pkg::STAT_OK) begin
				out_lg_q <= lg_q;
				out_pc_q <= qp_q[15:0];
				out_ac_q <= qa_q[15:0];
			end else begin
				out_lg_q <= '0;
				out_pc_q <= '0;
				out_ac_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {1'b0, out_ac_q, out_pc_q, out_lg_q, out_ch_q};

	pwmps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

`ifndef SYNTH
	// Drop ready right after a request transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer |=> !s_tready)
		else $error("ready held after request transfer");

	// Error results carry zero prescaler and counts
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != pwmps_pkg::STAT_OK) |-> (m_tdata[38:3] == '0))
		else $error("error result with nonzero counts");

	// Channel zero goes with a bad pin and only with it
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser == pwmps_pkg::STAT_BAD_PIN) ==
		              (m_tdata[2:0] == pwmps_pkg::CHAN_NONE)))
		else $error("channel and bad pin status disagree");

	// Prescaler stays inside the search range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:3] <= 4'(pwmps_pkg::MAX_LOG2)))
		else $error("prescaler beyond search range");

	// A divider answer only follows a launch
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (launched_q && div_state))
		else $error("divider done without launch");

	// Launch only into an idle divider
	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider launched while busy");
`endif

endmodule

// ===== tb/sv/pwm_prescale_period_solver_top_tb.sv =====
`timescale 1ns / 1ps

module pwm_prescale_period_solver_top_tb;

	// Request kinds carried on s_tuser
	typedef enum logic {
		OP_FREQ = 1'b0,
		OP_TIME = 1'b1
	} op_t;

	// Limits the solver works against
	localparam logic [8:0]      FIRST_PWM_PIN = 9'd267;
	localparam logic [8:0]      LAST_PWM_PIN  = 9'd270;
	localparam logic [2:0]      FIXED_CHANNEL = 3'd4;
	localparam longint unsigned COUNT_MAX     = 65535;
	localparam int              LOG2_MAX      = 8;
	localparam longint unsigned DUTY_LIMIT    = 1000;
	localparam longint unsigned HIGH_LIMIT    = 5000;
	localparam longint unsigned HIGH_LIMIT_4  = 2500;
	localparam longint unsigned NS_IN_SECOND  = 64'd1000000000;
	localparam logic [26:0]     CLOCK_RESET   = 27'd24000000;
	localparam logic [26:0]     CLOCK_MIN     = 27'd1000000;
	localparam logic [26:0]     CLOCK_MAX     = 27'd100000000;
	localparam logic [26:0]     CLOCK_ALL_SET = 27'h7ffffff;
	localparam int              SIDE_SEND     = 0;
	localparam int              SIDE_RECV     = 1;
	localparam int              SWEEP_ITEMS   = 125;

	typedef struct packed {
		op_t         op;
		logic [8:0]  pin;
		logic [19:0] freq_hz;
		logic [9:0]  duty;
		logic [19:0] high_us;
		logic [19:0] period_us;
	} pwm_request_t;

	typedef struct packed {
		pwmps_pkg::status_t status;
		logic [2:0]         channel;
		logic [3:0]         prescale_log2;
		logic [15:0]        period_count;
		logic [15:0]        active_count;
	} pwm_setting_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [26:0] cfg_data;

	pwm_setting_t pending_settings[$];
	logic [26:0]  clock_setting;
	int           calm_left[2];
	int           mismatches;
	int           requests_sent;
	int           results_checked;
	int           clock_writes;
	int           status_seen[6];

	pwm_prescale_period_solver_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop for a hung run
	initial begin
		#10ms;
		$display("pwm_prescale_period_solver_top_tb failed");
		$finish;
	end

	// Work out the prescaler and counts for one request at a given source clock
	function automatic pwm_setting_t solve_setting(input pwm_request_t rq,
			input logic [26:0] clk_hz);
		pwm_setting_t    r;
		longint unsigned src_hz;
		longint unsigned tick_ns;
		longint unsigned period_ns;
		longint unsigned active_ns;
		longint unsigned unit_ns;
		longint unsigned per_cnt;
		longint unsigned act_cnt;
		logic [2:0]      chan;

		r = '0;
		r.status = pwmps_pkg::STAT_OK;
		src_hz = (clk_hz == '0) ? 1 : clk_hz;
		tick_ns = NS_IN_SECOND / src_hz;

		if (rq.pin < FIRST_PWM_PIN || rq.pin > LAST_PWM_PIN) begin
			r.status = pwmps_pkg::STAT_BAD_PIN;
			return r;
		end
		chan = 3'(rq.pin - FIRST_PWM_PIN + 9'd1);
		r.channel = chan;

		if (rq.op == OP_FREQ) begin
			if (rq.freq_hz > src_hz / 1000) begin
				r.status = pwmps_pkg::STAT_BAD_FREQ;
				return r;
			end
			if (rq.duty > DUTY_LIMIT) begin
				r.status = pwmps_pkg::STAT_BAD_DUTY;
				return r;
			end
			if (rq.freq_hz == '0) begin
				r.status = pwmps_pkg::STAT_BAD_FREQ;
				return r;
			end
			period_ns = NS_IN_SECOND / rq.freq_hz;
			active_ns = period_ns / 1000 * rq.duty;
		end else begin
			if (rq.high_us > HIGH_LIMIT ||
					(chan == FIXED_CHANNEL && rq.high_us > HIGH_LIMIT_4)) begin
				r.status = pwmps_pkg::STAT_HIGH_LONG;
				return r;
			end
			period_ns = rq.period_us;
			period_ns = period_ns * 1000;
			active_ns = rq.high_us;
			active_ns = active_ns * 1000;
		end

		// Fixed channel: no search, counts wrap to 16 bits
		if (chan == FIXED_CHANNEL) begin
			r.period_count = 16'(period_ns / tick_ns);
			r.active_count = 16'(active_ns / tick_ns);
			return r;
		end

		// Smallest power-of-two prescaler where both counts fit
		for (int lg = 0; lg <= LOG2_MAX; lg++) begin
			unit_ns = tick_ns << lg;
			per_cnt = period_ns / unit_ns;
			act_cnt = active_ns / unit_ns;
			if (per_cnt <= COUNT_MAX && act_cnt <= COUNT_MAX) begin
				r.prescale_log2 = 4'(lg);
				r.period_count = 16'(per_cnt);
				r.active_count = 16'(act_cnt);
				return r;
			end
		end
		r.status = pwmps_pkg::STAT_NO_FIT;
		return r;
	endfunction

	function automatic pwm_request_t request_of(input op_t op, input int pin,
			input int freq_hz, input int duty, input int high_us,
			input int period_us);
		pwm_request_t rq;

		rq.op = op;
		rq.pin = 9'(pin);
		rq.freq_hz = 20'(freq_hz);
		rq.duty = 10'(duty);
		rq.high_us = 20'(high_us);
		rq.period_us = 20'(period_us);
		return rq;
	endfunction

	// Roughly log-uniform value up to 20 bits
	function automatic int unsigned spread_value();
		int unsigned k;

		k = $urandom_range(1, 20);
		return $urandom & ((32'd1 << k) - 1);
	endfunction

	// Mostly well-formed requests with random content, the rest noise
	function automatic pwm_request_t random_request(input logic [26:0] clk_hz);
		pwm_request_t rq;
		int unsigned  freq_cap;
		int unsigned  pick;

		rq.op = op_t'($urandom_range(0, 1));
		rq.pin = 9'($urandom);
		rq.freq_hz = 20'($urandom);
		rq.duty = 10'($urandom);
		rq.high_us = 20'($urandom);
		rq.period_us = 20'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 8) begin
			rq.pin = 9'($urandom_range(FIRST_PWM_PIN, LAST_PWM_PIN));
			freq_cap = ((clk_hz == '0) ? 1 : clk_hz) / 1000;
			rq.freq_hz = (freq_cap == 0) ? '0 : 20'(spread_value() % freq_cap + 1);
			case ($urandom_range(0, 5))
				0: rq.duty = '0;
				1: rq.duty = 10'(DUTY_LIMIT);
				default: rq.duty = 10'($urandom_range(0, DUTY_LIMIT));
			endcase
			rq.high_us = 20'($urandom_range(0,
				(rq.pin == LAST_PWM_PIN) ? HIGH_LIMIT_4 : HIGH_LIMIT));
			rq.period_us = 20'(spread_value());
		end else if (pick == 8) begin
			// valid pin with wild fields
			rq.pin = 9'($urandom_range(FIRST_PWM_PIN, LAST_PWM_PIN));
		end
		return rq;
	endfunction

	// Per-item wait with occasional stretches of back-to-back traffic
	function automatic int draw_wait(input int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left[side] = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	// Present one request and hold it until the transfer
	task automatic send_request(input pwm_request_t rq);
		int gap;

		gap = draw_wait(SIDE_SEND);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {1'b0, rq.period_us, rq.high_us, rq.duty, rq.freq_hz, rq.pin};
		s_tuser <= rq.op;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_settings.push_back(solve_setting(rq, clock_setting));
		requests_sent++;
	endtask

	// Write the source clock once the block has drained
	task automatic write_clock(input logic [26:0] hz);
		s_tvalid <= 1'b0;
		while (pending_settings.size() != 0) @(posedge clk);
		cfg_data <= hz;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		clock_setting = hz;
		clock_writes++;
	endtask

	task automatic test_pin_decode();
		send_request(request_of(OP_FREQ, 0, 1000, 500, 0, 0));
		send_request(request_of(OP_TIME, 511, 1048575, 1023, 1048575, 1048575));
		send_request(request_of(OP_FREQ, 266, 1000, 500, 0, 0));
		send_request(request_of(OP_TIME, 271, 0, 0, 100, 1000));
	endtask

	task automatic test_frequency_requests();
		// highest legal frequency at full duty
		send_request(request_of(OP_FREQ, 267, 24000, 1000, 0, 0));
		send_request(request_of(OP_FREQ, 268, 24001, 500, 0, 0));
		send_request(request_of(OP_FREQ, 269, 1000, 1001, 0, 0));
		send_request(request_of(OP_FREQ, 270, 0, 0, 0, 0));
		// slowest frequency cannot fit any prescaler
		send_request(request_of(OP_FREQ, 267, 1, 500, 0, 0));
		// duty is checked ahead of the zero frequency
		send_request(request_of(OP_FREQ, 270, 0, 1023, 0, 0));
		// fixed channel count wraps
		send_request(request_of(OP_FREQ, 270, 366, 1000, 0, 0));
		// frequency is checked ahead of duty
		send_request(request_of(OP_FREQ, 268, 1048575, 1023, 0, 0));
	endtask

	task automatic test_time_requests();
		send_request(request_of(OP_TIME, 267, 0, 0, 5000, 1048575));
		send_request(request_of(OP_TIME, 268, 0, 0, 5001, 100));
		send_request(request_of(OP_TIME, 270, 0, 0, 2500, 2500));
		send_request(request_of(OP_TIME, 270, 0, 0, 2501, 2500));
		send_request(request_of(OP_TIME, 269, 0, 0, 0, 0));
		// active time drives the prescaler choice
		send_request(request_of(OP_TIME, 267, 0, 0, 5000, 100));
		send_request(request_of(OP_TIME, 270, 0, 0, 0, 1048575));
		send_request(request_of(OP_TIME, 269, 0, 0, 1000, 65535));
	endtask

	// A zero clock behaves as one hertz
	task automatic test_zero_clock();
		write_clock('0);
		send_request(request_of(OP_FREQ, 267, 0, 0, 0, 0));
		send_request(request_of(OP_FREQ, 268, 1, 1000, 0, 0));
		send_request(request_of(OP_TIME, 269, 0, 0, 5000, 1048575));
		send_request(request_of(OP_TIME, 270, 0, 0, 2500, 1048575));
	endtask

	task automatic test_random_sweep(input logic [26:0] hz, input int count);
		write_clock(hz);
		repeat (count) send_request(random_request(clock_setting));
	endtask

	task automatic test_clock_settings();
		test_random_sweep('0, SWEEP_ITEMS);
		test_random_sweep(CLOCK_MIN, SWEEP_ITEMS);
		test_random_sweep(CLOCK_MAX, SWEEP_ITEMS);
		test_random_sweep(CLOCK_ALL_SET, SWEEP_ITEMS);
		test_random_sweep(CLOCK_RESET, SWEEP_ITEMS);
		test_random_sweep(27'($urandom_range(CLOCK_MIN, CLOCK_MAX)), SWEEP_ITEMS);
		test_random_sweep(27'($urandom_range(CLOCK_MIN, CLOCK_MAX)), SWEEP_ITEMS);
	endtask

	// Result side: random stalls, with calm stretches
	initial begin
		int w;

		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			w = draw_wait(SIDE_RECV);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// Compare each result transfer with the oldest expected setting
	always @(posedge clk) begin
		pwm_setting_t want;
		pwm_setting_t got;

		if (arst_n && m_tvalid && m_tready) begin
			got.status = pwmps_pkg::status_t'(m_tuser);
			got.channel = m_tdata[2:0];
			got.prescale_log2 = m_tdata[6:3];
			got.period_count = m_tdata[22:7];
			got.active_count = m_tdata[38:23];
			if (m_tuser <= pwmps_pkg::STAT_NO_FIT)
				status_seen[m_tuser]++;
			results_checked++;
			if (pending_settings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing pending: st %0d ch %0d lg %0d pc %0d ac %0d",
						$realtime, got.status, got.channel, got.prescale_log2,
						got.period_count, got.active_count);
			end else begin
				want = pending_settings.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch exp st %0d ch %0d lg %0d pc %0d ac %0d / got st %0d ch %0d lg %0d pc %0d ac %0d",
							$realtime, want.status, want.channel, want.prescale_log2,
							want.period_count, want.active_count, got.status,
							got.channel, got.prescale_log2, got.period_count,
							got.active_count);
				end
			end
		end
	end

	// Test sequence
	initial begin
		clock_setting = CLOCK_RESET;
		calm_left[SIDE_SEND] = 0;
		calm_left[SIDE_RECV] = 0;
		mismatches = 0;
		requests_sent = 0;
		results_checked = 0;
		clock_writes = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pin_decode();
		test_frequency_requests();
		test_time_requests();
		test_zero_clock();
		test_clock_settings();

		// Drain, then allow for a stray late result
		s_tvalid <= 1'b0;
		while (pending_settings.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("%0d requests under %0d clock writes, %0d results checked, %0d mismatches",
			requests_sent, clock_writes, results_checked, mismatches);
		$display("status mix: ok %0d, pin %0d, freq %0d, duty %0d, high %0d, no fit %0d",
			status_seen[pwmps_pkg::STAT_OK], status_seen[pwmps_pkg::STAT_BAD_PIN],
			status_seen[pwmps_pkg::STAT_BAD_FREQ], status_seen[pwmps_pkg::STAT_BAD_DUTY],
			status_seen[pwmps_pkg::STAT_HIGH_LONG], status_seen[pwmps_pkg::STAT_NO_FIT]);
		if (mismatches == 0 && pending_settings.size() == 0) begin
			$display("pwm_prescale_period_solver_top_tb passed");
		end else begin
			$display("pwm_prescale_period_solver_top_tb failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/pwmps_pkg.sv
rtl/core/pwmps_div.sv
rtl/core/pwm_prescale_period_solver_top.sv
tb/sv/pwm_prescale_period_solver_top_tb.sv
